[rtl/core/tcc_pkg.sv]
// Shared codes and types for the triple coincidence cube filler.
package tcc_pkg;

  localparam int EW = 16;
  localparam int MW = 5;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int COORD_W = 6;
  localparam int ST_W = 3;
  localparam int TC_W = 10;
  localparam int BC_W = 32;

  localparam logic [CFG_IW-1:0] CFG_ENERGY_MIN = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ENERGY_MAX = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_NEUTRON_LOW = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_NEUTRON_HIGH = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TOTAL_MODE = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_MIN_MULT = 3'd5;

  localparam logic FUNC_HIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [ST_W-1:0] ST_ACCEPT = 3'd0;
  localparam logic [ST_W-1:0] ST_NEUTRON_MISS = 3'd1;
  localparam logic [ST_W-1:0] ST_TOO_FEW = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [ST_W-1:0] ST_READ = 3'd4;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_POST  = 13'b0000000001000,
    S_RDW   = 13'b0000000010000,
    S_FA    = 13'b0000000100000,
    S_FB    = 13'b0000001000000,
    S_FC    = 13'b0000010000000,
    S_FD    = 13'b0000100000000,
    S_BRD   = 13'b0001000000000,
    S_BWR   = 13'b0010000000000,
    S_SPARE = 13'b0100000000000,
    S_END   = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[rtl/core/triple_coincidence_cube_filler.sv]
// Top level: hit binning, event judgement, triple fill sequencer and cube reads.
//
//  channel  ports                                    transfer when
//  in       start, busy, in_func .. in_read_z        start & !busy
//  out      out_valid, out_status, out_triple_count, out_valid (one cycle)
//           out_bin_count
//  cfg      cfg_we, cfg_index, cfg_data              cfg_we
//
// A hit inside the energy window passes through the bit-serial divider; a hit outside
// it skips the divider.
// An accepted event handles each unordered triple with three buffer reads and six
// read-modify-writes of the cube memory through its single port pair.
// After reset busy stays high while the cube is swept to zero. Results cannot be stalled.
module triple_coincidence_cube_filler import tcc_pkg::*; #(
  parameter int BINS = 64,
  parameter int MAX_HITS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [EW-1:0]     in_gamma_energy,
  input  logic [EW-1:0]     in_neutron_energy,
  input  logic              in_last_hit,
  input  logic [COORD_W-1:0] in_read_x,
  input  logic [COORD_W-1:0] in_read_y,
  input  logic [COORD_W-1:0] in_read_z,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [TC_W-1:0]   out_triple_count,
  output logic [BC_W-1:0]   out_bin_count,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int BW = $clog2(BINS);
  localparam int AW = 3 * BW;
  localparam int NW = EW + BW;
  localparam int IW = $clog2(MAX_HITS);
  localparam int HW = $clog2(MAX_HITS + 1);
  localparam int CMPW = (HW > MW) ? HW : MW;
  localparam int CW = COUNT_WIDTH;

  state_t state_r;

  logic [EW-1:0] emin_r, emax_r, nlo_r, nhi_r;
  logic          total_r;
  logic [MW-1:0] minm_r;

  logic          last_r;
  logic [EW-1:0] neut_r;
  logic          oor_r;
  logic [HW-1:0] ht_r;
  logic          ovf_r;
  logic [HW-1:0] i_r, j_r, k_r;
  logic [2:0]    p_r;
  logic [BW-1:0] a_r, b_r, c_r;
  logic [TC_W-1:0] tc_r;

  logic [BW-1:0] hit_bins [MAX_HITS];
  logic [BW-1:0] hb_rd_r;
  logic [IW-1:0] hb_raddr;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [TC_W-1:0]   out_tc_r;
  logic [BC_W-1:0]   out_bc_r;

  logic          accept;
  logic          in_range;
  logic [EW-1:0] diff;
  logic [NW-1:0] num;
  div_ctl_t      div_ctl;
  logic [BW-1:0] div_q;

  logic [AW-1:0] cube_raddr, perm_addr, rd_coord_addr;
  logic [CW-1:0] cube_rdata, cube_wdata;
  logic          cube_we, clearing;
  logic [BW+COORD_W-1:0] ext_x, ext_y, ext_z;
  logic          coord_oor;
  logic [CW+BC_W-1:0] cnt_ext;
  logic          nmiss;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_range = (in_gamma_energy >= emin_r) && (in_gamma_energy < emax_r);
  assign diff = in_gamma_energy - emin_r;
  assign num = NW'(diff) * NW'(BINS);
  assign div_ctl.start = accept && (in_func == FUNC_HIT) && in_range;

  tcc_div #(.BW(BW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_ctl.start), .num(num),
    .den(emax_r - emin_r), .quo(div_q), .done(div_ctl.done)
  );

  assign ext_x = {{BW{1'b0}}, in_read_x};
  assign ext_y = {{BW{1'b0}}, in_read_y};
  assign ext_z = {{BW{1'b0}}, in_read_z};
  assign coord_oor = (ext_x >= (BW+COORD_W)'(BINS)) || (ext_y >= (BW+COORD_W)'(BINS)) ||
                     (ext_z >= (BW+COORD_W)'(BINS));
  assign rd_coord_addr = {ext_x[BW-1:0], ext_y[BW-1:0], ext_z[BW-1:0]};

  always_comb begin
    case (p_r)
      3'd0: perm_addr = {a_r, b_r, c_r};
      3'd1: perm_addr = {a_r, c_r, b_r};
      3'd2: perm_addr = {b_r, a_r, c_r};
      3'd3: perm_addr = {b_r, c_r, a_r};
      3'd4: perm_addr = {c_r, a_r, b_r};
      default: perm_addr = {c_r, b_r, a_r};
    endcase
  end

  assign cube_raddr = (state_r == S_IDLE) ? rd_coord_addr : perm_addr;
  assign cube_we = (state_r == S_BWR);
  assign cube_wdata = (&cube_rdata) ? cube_rdata : cube_rdata + 1'b1;

  tcc_cube #(.AW(AW), .CW(CW)) u_cube (
    .clk(clk), .rst_n(rst_n), .rd_addr(cube_raddr), .rd_data(cube_rdata),
    .wr_en(cube_we), .wr_addr(perm_addr), .wr_data(cube_wdata), .clearing(clearing)
  );

  assign cnt_ext = {{BC_W{1'b0}}, cube_rdata};

  always_comb begin
    case (state_r)
      S_FB: hb_raddr = j_r[IW-1:0];
      S_FC: hb_raddr = k_r[IW-1:0];
      default: hb_raddr = i_r[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    hb_rd_r <= hit_bins[hb_raddr];
    if ((state_r == S_DIV) && div_ctl.done && (ht_r < HW'(MAX_HITS))) begin
      hit_bins[ht_r[IW-1:0]] <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emin_r <= '0;
      emax_r <= 16'd32768;
      nlo_r <= 16'd2560;
      nhi_r <= 16'd3840;
      total_r <= 1'b1;
      minm_r <= 5'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENERGY_MIN: emin_r <= cfg_data;
        CFG_ENERGY_MAX: emax_r <= cfg_data;
        CFG_NEUTRON_LOW: nlo_r <= cfg_data;
        CFG_NEUTRON_HIGH: nhi_r <= cfg_data;
        CFG_TOTAL_MODE: total_r <= cfg_data[0];
        CFG_MIN_MULT: minm_r <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  assign nmiss = !total_r && !((neut_r >= nlo_r) && (neut_r < nhi_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ht_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (!clearing) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            last_r <= in_last_hit;
            neut_r <= in_neutron_energy;
            oor_r <= coord_oor;
            if (in_func == FUNC_READ) begin
              state_r <= S_RDW;
            end else if (in_range) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_POST;
            end
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            if (ht_r < HW'(MAX_HITS)) begin
              ht_r <= ht_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (nmiss || ovf_r || (CMPW'(ht_r) < CMPW'(minm_r)) ||
                       (ht_r < HW'(3))) begin
            out_valid_r <= 1'b1;
            out_tc_r <= '0;
            out_bc_r <= '0;
            if (nmiss) begin
              out_status_r <= ST_NEUTRON_MISS;
            end else if (ovf_r) begin
              out_status_r <= ST_OVERFLOW;
            end else if (CMPW'(ht_r) < CMPW'(minm_r)) begin
              out_status_r <= ST_TOO_FEW;
            end else begin
              out_status_r <= ST_ACCEPT;
            end
            ht_r <= '0;
            ovf_r <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            i_r <= HW'(0);
            j_r <= HW'(1);
            k_r <= HW'(2);
            tc_r <= '0;
            state_r <= S_FA;
          end
        end
        S_RDW: begin
          out_valid_r <= 1'b1;
          out_status_r <= ST_READ;
          out_tc_r <= '0;
          out_bc_r <= oor_r ? '0 : cnt_ext[BC_W-1:0];
          state_r <= S_IDLE;
        end
        S_FA: state_r <= S_FB;
        S_FB: begin
          a_r <= hb_rd_r;
          state_r <= S_FC;
        end
        S_FC: begin
          b_r <= hb_rd_r;
          state_r <= S_FD;
        end
        S_FD: begin
          c_r <= hb_rd_r;
          p_r <= 3'd0;
          state_r <= S_BRD;
        end
        S_BRD: state_r <= S_BWR;
        S_BWR: begin
          if (p_r == 3'd5) begin
            tc_r <= tc_r + 1'b1;
            state_r <= S_FA;
            if (({1'b0, k_r} + (HW+1)'(1)) < {1'b0, ht_r}) begin
              k_r <= k_r + 1'b1;
            end else if (({1'b0, j_r} + (HW+1)'(2)) < {1'b0, ht_r}) begin
              j_r <= j_r + 1'b1;
              k_r <= j_r + HW'(2);
            end else if (({1'b0, i_r} + (HW+1)'(3)) < {1'b0, ht_r}) begin
              i_r <= i_r + 1'b1;
              j_r <= i_r + HW'(2);
              k_r <= i_r + HW'(3);
            end else begin
              state_r <= S_END;
            end
          end else begin
            p_r <= p_r + 1'b1;
            state_r <= S_BRD;
          end
        end
        S_END: begin
          out_valid_r <= 1'b1;
          out_status_r <= ST_ACCEPT;
          out_tc_r <= tc_r;
          out_bc_r <= '0;
          ht_r <= '0;
          ovf_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_triple_count = out_tc_r;
  assign out_bin_count = out_bc_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ht_r <= HW'(MAX_HITS)) else $error("hit buffer count past depth");
  a_read_no_triples: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_READ) |-> (out_triple_count == '0))
    else $error("read result carries a triple count");
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy) else $error("ready while cube sweep runs");

endmodule

[rtl/core/tcc_div.sv]
// Iterative restoring divider for the energy bin, one quotient bit per cycle.
module tcc_div import tcc_pkg::*; #(
  parameter int BW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [EW+BW-1:0] num,
  input  logic [EW-1:0]    den,
  output logic [BW-1:0]    quo,
  output logic             done
);

  localparam int NW = EW + BW;
  localparam int CNTW = $clog2(BW + 1);

  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   dvs_r;
  logic [BW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic            ge;

  assign ge = rem_r >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(BW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dvs_r <= NW'(den) << (BW - 1);
      quo_r <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= (quo_r << 1) | BW'(ge);
      dvs_r <= dvs_r >> 1;
    end
  end

  assign quo = quo_r;
  assign done = done_r;

endmodule

[rtl/core/tcc_cube.sv]
// Cube counter memory with registered read and a clearing sweep after reset.
module tcc_cube #(
  parameter int AW = 18,
  parameter int CW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [CW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_data,
  output logic          clearing
);

  localparam int DEPTH = 1 << AW;

  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] rd_data_r;
  logic [AW:0]   clr_cnt_r;

  assign clearing = ~clr_cnt_r[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
